### rtl/itda_pkg.sv
// itda_pkg: shared types and constants for the decimal ascii converter
// no dependencies; used by itda_front, itda_back and int_to_decimal_ascii

package itda_pkg;

  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned MAX_DIGITS = 10;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  // floor(n / 10) == (n * RECIP10) >> RECIP10_SHIFT for every 32-bit n
  localparam logic [VALUE_W-1:0] RECIP10       = 32'hCCCC_CCCD;
  localparam int unsigned        RECIP10_SHIFT = 35;

  // classified number: magnitude and whether a minus sign leads it
  typedef struct packed {
    logic               neg;
    logic [VALUE_W-1:0] mag;
  } item_t;

  // head of the front queue as the back end sees it
  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

endpackage

### rtl/itda_front.sv
// itda_front: accepts numbers, splits off the sign, and holds them in a short queue
// depends on itda_pkg

module itda_front #(
  parameter int unsigned QDEPTH = itda_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  output logic                         full,
  input  logic [itda_pkg::VALUE_W-1:0] in_value,
  input  logic                         in_is_signed,
  output itda_pkg::q_head_t            head,
  input  logic                         take
);

  localparam int unsigned PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CW = $clog2(QDEPTH + 1);

  itda_pkg::item_t mem_r [QDEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  itda_pkg::item_t cls;
  logic            do_wr, do_rd;

  // negative only when read as signed; magnitude of the most negative value fits unsigned
  always_comb begin
    cls.neg = in_is_signed & in_value[itda_pkg::VALUE_W-1];
    cls.mag = cls.neg ? (~in_value + 1'b1) : in_value;
  end

  assign full  = (cnt_r == CW'(QDEPTH));
  assign do_wr = push & ~full;
  assign do_rd = take & (cnt_r != '0);

  assign head.valid = (cnt_r != '0);
  assign head.item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= cls;
    end
  end

endmodule

### rtl/itda_back.sv
// itda_back: peels decimal digits off with a reciprocal multiply, then emits sign and digits
// depends on itda_pkg; fed by itda_front

module itda_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  itda_pkg::q_head_t           head,
  output logic                        take,
  output logic                        out_valid,
  output logic [itda_pkg::CHAR_W-1:0] out_char,
  output logic                        out_last,
  input  logic                        out_take
);

  localparam int unsigned VW   = itda_pkg::VALUE_W;
  localparam int unsigned DW   = itda_pkg::DIGIT_W;
  localparam int unsigned IW   = $clog2(itda_pkg::MAX_DIGITS);
  localparam int unsigned NW   = $clog2(itda_pkg::MAX_DIGITS + 1);
  localparam int unsigned QW   = 2 * VW - itda_pkg::RECIP10_SHIFT;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_SIGN = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t                      state_r, state_nxt;
  logic [VW-1:0]               cur_r, cur_nxt;
  logic                        neg_r, neg_nxt;
  logic [NW-1:0]               nd_r, nd_nxt;
  logic [DW-1:0]               dig_r [itda_pkg::MAX_DIGITS];
  logic                        out_valid_r, out_valid_nxt;
  logic [itda_pkg::CHAR_W-1:0] out_char_r, out_char_nxt;
  logic                        out_last_r, out_last_nxt;

  logic [2*VW-1:0] prod;
  logic [QW-1:0]   quot;
  logic [DW-1:0]   quot10_lo;
  logic [DW-1:0]   digit;
  logic [NW-1:0]   nd_dec;
  logic            out_free;
  logic            dig_wr;

  // one reciprocal multiply per digit; only the low nibble of q*10 matters for the remainder
  assign prod      = cur_r * itda_pkg::RECIP10;
  assign quot      = prod[2*VW-1:itda_pkg::RECIP10_SHIFT];
  assign quot10_lo = {quot[DW-4:0], 3'b000} + {quot[DW-2:0], 1'b0};
  assign digit     = cur_r[DW-1:0] - quot10_lo;
  assign nd_dec    = nd_r - 1'b1;

  assign out_free  = ~out_valid_r | out_take;
  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    neg_nxt       = neg_r;
    nd_nxt        = nd_r;
    take          = 1'b0;
    dig_wr        = 1'b0;
    out_valid_nxt = out_valid_r & ~out_take;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      ST_IDLE: begin
        if (head.valid) begin
          take      = 1'b1;
          cur_nxt   = head.item.mag;
          neg_nxt   = head.item.neg;
          nd_nxt    = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        dig_wr  = 1'b1;
        nd_nxt  = nd_r + 1'b1;
        cur_nxt = VW'(quot);
        if (quot == '0) begin
          state_nxt = neg_r ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = itda_pkg::CHAR_MINUS;
          out_last_nxt  = 1'b0;
          state_nxt     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = itda_pkg::CHAR_ZERO + {{(itda_pkg::CHAR_W-DW){1'b0}},
                                                 dig_r[nd_dec[IW-1:0]]};
          out_last_nxt  = (nd_r == NW'(1));
          nd_nxt        = nd_dec;
          if (nd_r == NW'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    neg_r      <= neg_nxt;
    nd_r       <= nd_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    if (dig_wr) begin
      dig_r[nd_r[IW-1:0]] <= digit;
    end
  end

endmodule

### rtl/int_to_decimal_ascii.sv
// int_to_decimal_ascii: top level of the 32-bit integer to decimal text converter
// depends on itda_pkg, itda_front and itda_back
//
//   channel  handshake     payload
//   input    push / full   in_value[31:0], in_is_signed
//   output   empty / pop   out_ascii_char[7:0], out_last
//
// a number's digits are extracted first (one reciprocal multiply per digit), then
// its characters are sent, one per cycle while the output is not stalled.
// the front queue keeps taking numbers while the back end converts.
// rst_n is synchronous and clears the queue, the sequencer and the output register.
// a stalled output holds the sequencer; the queue still fills until full.

module int_to_decimal_ascii #(
  parameter int unsigned QDEPTH = itda_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  output logic                         full,
  input  logic [itda_pkg::VALUE_W-1:0] in_value,
  input  logic                         in_is_signed,
  output logic                         empty,
  input  logic                         pop,
  output logic [itda_pkg::CHAR_W-1:0]  out_ascii_char,
  output logic                         out_last
);

  itda_pkg::q_head_t head;
  logic              take;
  logic              out_valid;

  itda_front #(
    .QDEPTH (QDEPTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_value     (in_value),
    .in_is_signed (in_is_signed),
    .head         (head),
    .take         (take)
  );

  itda_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .take      (take),
    .out_valid (out_valid),
    .out_char  (out_ascii_char),
    .out_last  (out_last),
    .out_take  (pop)
  );

  assign empty = ~out_valid;

endmodule

### dv/itda_checker.sv
// itda_checker: watches both channels of int_to_decimal_ascii and predicts its decimal text
// depends on itda_pkg; hands a mismatch count and the number of characters still due to tb_top

module itda_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  logic                         full,
  input  logic [itda_pkg::VALUE_W-1:0] in_value,
  input  logic                         in_is_signed,
  input  logic                         empty,
  input  logic                         pop,
  input  logic [itda_pkg::CHAR_W-1:0]  out_ascii_char,
  input  logic                         out_last,
  output int                           fail_count,
  output int                           chars_waiting
);

  localparam int unsigned DECIMAL_BASE = 10;

  typedef struct packed {
    logic [itda_pkg::CHAR_W-1:0] ch;
    logic                        last;
  } text_char_t;

  // characters still owed by the block, oldest first
  text_char_t expected_text[$];

  initial begin
    fail_count    = 0;
    chars_waiting = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    fail_count++;
  endtask

  function automatic void predict_decimal_text(input logic [itda_pkg::VALUE_W-1:0] value,
                                               input logic is_signed);
    logic                         neg;
    logic [itda_pkg::VALUE_W-1:0] mag;
    logic [itda_pkg::DIGIT_W-1:0] digits [itda_pkg::MAX_DIGITS];
    int                           n;
    text_char_t                   tc;
    neg = is_signed & value[itda_pkg::VALUE_W-1];
    // magnitude taken as unsigned, so the most negative value needs no special path
    mag = neg ? (32'd0 - value) : value;
    n   = 0;
    if (mag == '0) begin
      tc.ch   = itda_pkg::CHAR_ZERO;
      tc.last = 1'b1;
      expected_text.push_back(tc);
      return;
    end
    while (mag != '0) begin
      digits[n] = itda_pkg::DIGIT_W'(mag % DECIMAL_BASE);
      mag       = mag / DECIMAL_BASE;
      n++;
    end
    if (neg) begin
      tc.ch   = itda_pkg::CHAR_MINUS;
      tc.last = 1'b0;
      expected_text.push_back(tc);
    end
    for (int i = n - 1; i >= 0; i--) begin
      tc.ch   = itda_pkg::CHAR_ZERO + itda_pkg::CHAR_W'(digits[i]);
      tc.last = (i == 0);
      expected_text.push_back(tc);
    end
  endfunction

  always @(posedge clk) begin
    text_char_t exp_c;
    if (!rst_n) begin
      expected_text.delete();
    end else begin
      if (push && !full) begin
        predict_decimal_text(in_value, in_is_signed);
      end
      if (pop && !empty) begin
        if (expected_text.size() == 0) begin
          report_mismatch($sformatf("char 0x%02h last %0b with nothing expected",
                                    out_ascii_char, out_last));
        end else begin
          exp_c = expected_text.pop_front();
          if (out_ascii_char !== exp_c.ch) begin
            report_mismatch($sformatf("ascii_char 0x%02h, expected 0x%02h",
                                      out_ascii_char, exp_c.ch));
          end
          if (out_last !== exp_c.last) begin
            report_mismatch($sformatf("last %0b, expected %0b on char 0x%02h",
                                      out_last, exp_c.last, exp_c.ch));
          end
        end
      end
    end
    chars_waiting = expected_text.size();
  end

endmodule

### dv/tb_top.sv
// tb_top: stimulus, receiver pacing, watchdog and verdict for int_to_decimal_ascii
// depends on itda_pkg, the int_to_decimal_ascii rtl and itda_checker

module tb_top;

  localparam int STALL_LIMIT    = 5000;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int RANDOM_ITEMS   = 250;
  localparam int DRAIN_CYCLES   = 40;

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         push;
  logic                         full;
  logic [itda_pkg::VALUE_W-1:0] in_value;
  logic                         in_is_signed;
  logic                         empty;
  logic                         pop;
  logic [itda_pkg::CHAR_W-1:0]  out_ascii_char;
  logic                         out_last;
  int                           fail_count;
  int                           chars_waiting;

  int                           tx_gap_max = 10;
  int                           rx_gap_max = 10;
  bit                           rx_hold_req = 1'b0;
  int                           idle_cycles = 0;
  logic [itda_pkg::VALUE_W-1:0] pow10 [itda_pkg::MAX_DIGITS];

  int_to_decimal_ascii i_dut (.*);

  itda_checker i_checker (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // any accepted transaction on either side restarts the count
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("int_to_decimal_ascii test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_number(input logic [itda_pkg::VALUE_W-1:0] v, input logic s);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_value     <= v;
    in_is_signed <= s;
    push         <= 1'b1;
    do @(posedge clk); while (full);
    @(negedge clk);
  endtask

  task automatic wait_all_chars;
    push <= 1'b0;
    do @(negedge clk); while (chars_waiting != 0);
  endtask

  // receiver: random pop gaps, plus one long hold-off on request
  initial begin
    int gap;
    pop = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (rx_hold_req) begin
        pop <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(negedge clk);
        rx_hold_req = 1'b0;
      end else begin
        gap = $urandom_range(0, rx_gap_max);
        if (gap > 0) begin
          pop <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      @(negedge clk);
    end
  end

  initial begin
    logic [itda_pkg::VALUE_W-1:0] v;
    rst_n        = 1'b0;
    push         = 1'b0;
    in_value     = '0;
    in_is_signed = 1'b0;
    pow10[0]     = 32'd1;
    for (int i = 1; i < itda_pkg::MAX_DIGITS; i++) pow10[i] = pow10[i-1] * 10;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: zero both ways, digit boundaries, sign edges, ten-digit values
    send_number(32'd0, 1'b0);
    send_number(32'd0, 1'b1);
    send_number(32'd1, 1'b0);
    send_number(32'd9, 1'b1);
    send_number(32'd10, 1'b0);
    send_number(32'd99, 1'b1);
    send_number(32'd100, 1'b0);
    send_number(32'hFFFF_FFFF, 1'b0);
    send_number(32'hFFFF_FFFF, 1'b1);
    send_number(32'h8000_0000, 1'b1);
    send_number(32'h8000_0000, 1'b0);
    send_number(32'h7FFF_FFFF, 1'b1);
    send_number(32'h7FFF_FFFF, 1'b0);
    send_number(32'd1_000_000_000, 1'b0);
    send_number(32'd999_999_999, 1'b1);
    send_number(32'hFFFF_FFF6, 1'b1);
    send_number(32'hFFFF_FFF6, 1'b0);
    send_number(32'hAAAA_AAAA, 1'b1);
    send_number(32'h5555_5555, 1'b0);
    send_number(32'hC465_3600, 1'b1);

    // sender pause until the block has drained
    wait_all_chars();

    // receiver held off while the sender keeps pushing back to back
    tx_gap_max  = 0;
    rx_hold_req = 1'b1;
    for (int i = 0; i < 30; i++) send_number($urandom, 1'($urandom_range(0, 1)));
    wait_all_chars();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 50 == 0) begin
        tx_gap_max = $urandom_range(0, 1) ? 10 : 0;
        rx_gap_max = $urandom_range(0, 1) ? 10 : 0;
      end
      case ($urandom_range(0, 4))
        0:       v = $urandom;
        1:       v = $urandom_range(0, 99);
        2:       v = pow10[$urandom_range(0, itda_pkg::MAX_DIGITS - 1)] - $urandom_range(0, 1);
        3:       v = 32'h8000_0000 | $urandom;
        default: v = 32'd0 - $urandom_range(1, 1000);
      endcase
      send_number(v, 1'($urandom_range(0, 1)));
    end

    wait_all_chars();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && chars_waiting == 0) begin
      $display("int_to_decimal_ascii test passed");
    end else begin
      $display("int_to_decimal_ascii test failed");
    end
    $finish;
  end

endmodule

### int_to_decimal_ascii.f
rtl/itda_pkg.sv
rtl/itda_front.sv
rtl/itda_back.sv
rtl/int_to_decimal_ascii.sv
dv/itda_checker.sv
dv/tb_top.sv
